// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Needs nothing else; take it in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/dltq_pkg.sv
// Shared types and constants of the delta-list timer queue.
// No dependencies; imported by the cell and the top level.
package dltq_pkg;

    localparam int MAX_TIMERS = 16;
    localparam int DELAY_BITS = 32;
    localparam int ID_BITS    = 8;
    localparam int TICK_BITS  = 16;
    localparam int COUNT_W    = $clog2(MAX_TIMERS + 1);

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_ZERO     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_DUP      = 3'd5;

    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [DELAY_BITS-1:0] delta;
    } t_entry;

    // Insertion word traveling down the chain.
    typedef struct packed {
        logic                  valid;
        logic                  push;   // 1: ripple shift, 0: still searching
        logic [ID_BITS-1:0]    id;
        logic [DELAY_BITS-1:0] delta;
    } t_tok;

    typedef struct packed {
        logic                 shift;  // take neighbor's entry
        logic                 merge;  // take neighbor, delta = own + neighbor
        logic                 dec;    // lower own delta by amt
        logic [TICK_BITS-1:0] amt;
    } t_cell_ctl;

endpackage

// File: hw/rtl/delta_list_timer_queue_core.sv
// Top level of the delta-list timer queue: command control and the cell chain.
// Depends on dltq_pkg and dltq_cell.
//
//  channel   handshake            payload
//  --------  -------------------  ------------------------------------------
//  command   start / busy         i_opcode, i_timer_id, i_delay
//  result    o_strobe (1 cycle)   o_status, o_expired_valid, o_expired_id
//  config    i_cfg_we             i_cfg_wdata (tick amount)
//
// Tick, remove, refused adds and the unused opcode register the command, then
// update the chain and raise the strobe at the same clock edge.
// An accepted add sends an insertion word down the chain; it moves one cell per
// clock until it lands in the first free cell, and once no cell holds it, the
// control counts the new entry and raises the strobe.
// Reset empties the queue and sets the tick amount to 1; cell contents stay.
// The result strobe cannot be stalled; busy drops in the strobe cycle.
module delta_list_timer_queue_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [dltq_pkg::TICK_BITS-1:0] i_cfg_wdata,
    input  logic [1:0]                    i_opcode,
    input  logic [dltq_pkg::ID_BITS-1:0]  i_timer_id,
    input  logic [dltq_pkg::DELAY_BITS-1:0] i_delay,
    output logic                          o_strobe,
    output logic [2:0]                    o_status,
    output logic                          o_expired_valid,
    output logic [dltq_pkg::ID_BITS-1:0]  o_expired_id
);
    import dltq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_WALK = 2'd2;

    logic [1:0]            r_state, n_state;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [TICK_BITS-1:0]  r_tick;
    logic [1:0]            r_op;
    logic [ID_BITS-1:0]    r_id;
    logic [DELAY_BITS-1:0] r_delay;
    t_tok                  r_tok0, n_tok0;

    logic                  n_stb, n_ev;
    logic [2:0]            n_status;
    logic [ID_BITS-1:0]    n_eid;

    t_entry    ent [MAX_TIMERS];
    t_tok      tok [MAX_TIMERS+1];
    t_cell_ctl ctl [MAX_TIMERS];
    logic [MAX_TIMERS-1:0] occ, match;
    logic found, tok_busy, head_expire;

    // occupancy follows the fill count; ids are compared in parallel
    always_comb begin
        found    = 1'b0;
        tok_busy = r_tok0.valid;
        for (int k = 0; k < MAX_TIMERS; k++) begin
            occ[k]   = COUNT_W'(k) < r_count;
            match[k] = occ[k] && (ent[k].id == r_id);
            found    = found | match[k];
            tok_busy = tok_busy | tok[k+1].valid;
        end
        head_expire = ent[0].delta <= DELAY_BITS'(r_tick);
    end

    assign tok[0] = r_tok0;

    always_comb begin
        logic pre;
        pre      = 1'b0;
        n_state  = r_state;
        n_count  = r_count;
        n_tok0   = '0;
        n_stb    = 1'b0;
        n_status = o_status;
        n_ev     = 1'b0;
        n_eid    = '0;
        for (int k = 0; k < MAX_TIMERS; k++) begin
            ctl[k]     = '0;
            ctl[k].amt = r_tick;
        end
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_IDLE;
                n_stb    = 1'b1;
                n_status = ST_DONE;
                case (r_op)
                    OP_TICK: begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                        end else if (head_expire) begin
                            // pop the head: the whole chain steps left
                            for (int k = 0; k < MAX_TIMERS; k++) begin
                                ctl[k].shift = 1'b1;
                            end
                            n_count = r_count - COUNT_W'(1);
                            n_ev    = 1'b1;
                            n_eid   = ent[0].id;
                        end else begin
                            ctl[0].dec = 1'b1;
                        end
                    end
                    OP_ADD: begin
                        if (r_delay == '0) begin
                            n_status = ST_ZERO;
                        end else if (found) begin
                            n_status = ST_DUP;
                        end else if (r_count == COUNT_W'(MAX_TIMERS)) begin
                            n_status = ST_FULL;
                        end else begin
                            // launch the insertion word into cell 0
                            n_stb        = 1'b0;
                            n_state      = S_WALK;
                            n_tok0.valid = 1'b1;
                            n_tok0.push  = 1'b0;
                            n_tok0.id    = r_id;
                            n_tok0.delta = r_delay;
                        end
                    end
                    OP_REMOVE: begin
                        if (!found) begin
                            n_status = ST_NOTFOUND;
                        end else begin
                            // matched cell merges with its successor, later cells shift
                            for (int k = 0; k < MAX_TIMERS; k++) begin
                                ctl[k].merge = match[k];
                                ctl[k].shift = pre;
                                pre          = pre | match[k];
                            end
                            n_count = r_count - COUNT_W'(1);
                        end
                    end
                    default: begin
                        n_status = ST_DONE;
                    end
                endcase
            end
            S_WALK: begin
                // word has settled once no cell holds it any more
                if (!tok_busy) begin
                    n_count  = r_count + COUNT_W'(1);
                    n_stb    = 1'b1;
                    n_status = ST_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
        t_entry nbr;
        logic   nbr_occ;
        if (g == MAX_TIMERS - 1) begin : g_last
            assign nbr     = '0;
            assign nbr_occ = 1'b0;
        end else begin : g_mid
            assign nbr     = ent[g+1];
            assign nbr_occ = occ[g+1];
        end
        dltq_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_occ     (occ[g]),
            .i_nbr_occ (nbr_occ),
            .i_nbr     (nbr),
            .i_tok     (tok[g]),
            .i_ctl     (ctl[g]),
            .o_entry   (ent[g]),
            .o_tok     (tok[g+1])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_tick   <= TICK_BITS'(1);
            r_tok0   <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_tok0   <= n_tok0;
            o_strobe <= n_stb;
            if (i_cfg_we) begin
                r_tick <= i_cfg_wdata;
            end
        end
    end

    // hold the command word and the result payload
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op    <= i_opcode;
            r_id    <= i_timer_id;
            r_delay <= i_delay;
        end
        o_status        <= n_status;
        o_expired_valid <= n_ev;
        o_expired_id    <= n_eid;
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: hw/rtl/dltq_cell.sv
// One slot of the delta list: an entry plus a registered insertion word.
// Depends on dltq_pkg.
module dltq_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_occ,
    input  logic               i_nbr_occ,
    input  dltq_pkg::t_entry   i_nbr,
    input  dltq_pkg::t_tok     i_tok,
    input  dltq_pkg::t_cell_ctl i_ctl,
    output dltq_pkg::t_entry   o_entry,
    output dltq_pkg::t_tok     o_tok
);
    import dltq_pkg::*;

    t_entry r_entry, n_entry;
    t_tok   r_tok, n_tok;
    logic [DELAY_BITS:0] sum;

    always_comb begin
        n_entry = r_entry;
        n_tok   = '0;
        sum     = {1'b0, r_entry.delta} + {1'b0, i_nbr.delta};
        if (i_ctl.merge && i_nbr_occ) begin
            // fold removed delta into successor, saturate
            n_entry.id    = i_nbr.id;
            n_entry.delta = sum[DELAY_BITS] ? {DELAY_BITS{1'b1}} : sum[DELAY_BITS-1:0];
        end else if (i_ctl.shift || i_ctl.merge) begin
            n_entry = i_nbr;
        end else if (i_ctl.dec) begin
            n_entry.delta = r_entry.delta - DELAY_BITS'(i_ctl.amt);
        end else if (i_tok.valid) begin
            if (!i_occ) begin
                n_entry.id    = i_tok.id;
                n_entry.delta = i_tok.delta;
            end else if (i_tok.push || (r_entry.delta > i_tok.delta)) begin
                // take the word, pass own entry down
                n_entry.id    = i_tok.id;
                n_entry.delta = i_tok.delta;
                n_tok.valid   = 1'b1;
                n_tok.push    = 1'b1;
                n_tok.id      = r_entry.id;
                n_tok.delta   = i_tok.push ? r_entry.delta : r_entry.delta - i_tok.delta;
            end else begin
                n_tok.valid = 1'b1;
                n_tok.push  = 1'b0;
                n_tok.id    = i_tok.id;
                n_tok.delta = i_tok.delta - r_entry.delta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_entry = r_entry;
    assign o_tok   = r_tok;

endmodule

// File: hw/rtl/dltq_checker.sv
// Port-level checks of the timer queue core, bound to the top level.
// Depends on dltq_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dltq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           o_strobe,
    input logic [2:0]                     o_status,
    input logic                           o_expired_valid,
    input logic [dltq_pkg::ID_BITS-1:0]   o_expired_id
);
    import dltq_pkg::*;

    `ASSERT_IMPLY(a_stb_not_busy, i_clk, i_rst_n, o_strobe, !busy)
    `ASSERT_IMPLY(a_exp_with_stb, i_clk, i_rst_n, o_expired_valid,
                  o_strobe && (o_status == ST_DONE))
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy && !o_strobe)
    `ASSERT_IMPLY(a_no_exp_id, i_clk, i_rst_n, o_strobe && !o_expired_valid,
                  o_expired_id == '0)

endmodule

bind delta_list_timer_queue_core dltq_checker u_dltq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_status        (o_status),
    .o_expired_valid (o_expired_valid),
    .o_expired_id    (o_expired_id)
);

// File: test/testbench.sv
// Testbench for delta_list_timer_queue_core: directed and random command words
// checked against an in-bench delta-list predictor. Depends on dltq_pkg and the RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dltq_pkg::*;

    // The opcode left free by the package; the block answers it with a plain done.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_GAP = 60;

    typedef struct packed {
        logic [2:0]         status;
        logic               exp_valid;
        logic [ID_BITS-1:0] exp_id;
    } t_timer_result;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic                  i_cfg_we = 1'b0;
    logic [TICK_BITS-1:0]  i_cfg_wdata = '0;
    logic [1:0]            i_opcode = OP_TICK;
    logic [ID_BITS-1:0]    i_timer_id = '0;
    logic [DELAY_BITS-1:0] i_delay = '0;
    logic                  o_strobe;
    logic [2:0]            o_status;
    logic                  o_expired_valid;
    logic [ID_BITS-1:0]    o_expired_id;

    always #5 i_clk = ~i_clk;

    delta_list_timer_queue_core i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_opcode       (i_opcode),
        .i_timer_id     (i_timer_id),
        .i_delay        (i_delay),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_expired_valid(o_expired_valid),
        .o_expired_id   (o_expired_id)
    );

    // ------------------------------------------------------------------
    // Predictor state: the delta list as the block should hold it
    // ------------------------------------------------------------------
    logic [ID_BITS-1:0]    q_id    [MAX_TIMERS];
    logic [DELAY_BITS-1:0] q_delta [MAX_TIMERS];
    int                    q_count = 0;
    logic [TICK_BITS-1:0]  tick_amt = TICK_BITS'(1);

    t_timer_result pending_results[$];

    int idle_pct = 0;
    int n_fail = 0;
    int n_words = 0;
    int n_expired = 0;
    int n_refused = 0;
    int n_settings = 0;

    // Return the slot of a queued id, or -1 when it is not queued.
    function automatic int find_timer(logic [ID_BITS-1:0] id);
        for (int i = 0; i < q_count; i++) begin
            if (q_id[i] == id) return i;
        end
        return -1;
    endfunction

    // Close the gap left by the entry at pos.
    function automatic void drop_entry(int pos);
        for (int i = pos + 1; i < q_count; i++) begin
            q_id[i-1]    = q_id[i];
            q_delta[i-1] = q_delta[i];
        end
        q_count--;
    endfunction

    // Apply one command word to the predicted list and return the expected result.
    function automatic t_timer_result apply_timer_cmd(logic [1:0] op, logic [ID_BITS-1:0] id,
                                                      logic [DELAY_BITS-1:0] dly);
        t_timer_result r;
        logic [DELAY_BITS-1:0] rest;
        logic [DELAY_BITS:0]   sum;
        int pos;
        r = '{status: ST_DONE, exp_valid: 1'b0, exp_id: '0};
        case (op)
            OP_TICK: begin
                if (q_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (q_delta[0] > DELAY_BITS'(tick_amt)) begin
                    q_delta[0] = q_delta[0] - DELAY_BITS'(tick_amt);
                end else begin
                    // Head expires; any overshoot is dropped, not carried to the next entry.
                    r.exp_valid = 1'b1;
                    r.exp_id    = q_id[0];
                    drop_entry(0);
                end
            end
            OP_ADD: begin
                // Zero delay wins over duplicate, duplicate wins over full.
                if (dly == '0) begin
                    r.status = ST_ZERO;
                end else if (find_timer(id) >= 0) begin
                    r.status = ST_DUP;
                end else if (q_count >= MAX_TIMERS) begin
                    r.status = ST_FULL;
                end else begin
                    rest = dly;
                    pos  = 0;
                    // Equal expiry walks past: the new timer lands behind its peers.
                    while (pos < q_count && q_delta[pos] <= rest) begin
                        rest = rest - q_delta[pos];
                        pos++;
                    end
                    for (int i = q_count; i > pos; i--) begin
                        q_id[i]    = q_id[i-1];
                        q_delta[i] = q_delta[i-1];
                    end
                    q_id[pos]    = id;
                    q_delta[pos] = rest;
                    q_count++;
                    if (pos + 1 < q_count) q_delta[pos+1] = q_delta[pos+1] - rest;
                end
            end
            OP_REMOVE: begin
                pos = find_timer(id);
                if (pos < 0) begin
                    r.status = ST_NOTFOUND;
                end else begin
                    if (pos + 1 < q_count) begin
                        // Hand the removed delta to the successor, saturating.
                        sum = {1'b0, q_delta[pos+1]} + {1'b0, q_delta[pos]};
                        q_delta[pos+1] = sum[DELAY_BITS] ? '1 : sum[DELAY_BITS-1:0];
                    end
                    drop_entry(pos);
                end
            end
            default: ;
        endcase
        if (op == OP_ADD && r.status != ST_DONE) n_refused++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobe must match the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_timer_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing expected: status %0d expired %0d id %0d",
                       o_status, o_expired_valid, o_expired_id);
                n_fail++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    n_fail++;
                end
                if (o_expired_valid !== want.exp_valid) begin
                    $error("expired_valid: expected %0d, got %0d",
                           want.exp_valid, o_expired_valid);
                    n_fail++;
                end
                if (o_expired_id !== want.exp_id) begin
                    $error("expired_id: expected %0d, got %0d", want.exp_id, o_expired_id);
                    n_fail++;
                end
                if (want.exp_valid) n_expired++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no word moves for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("timeout: no word accepted or returned for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // Draw an idle stretch for the sender from the current idle rate.
    function automatic int pick_gap();
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        return gap;
    endfunction

    // Send one command word: idle first if drawn, hold start until accepted,
    // then log the expected result. Start stays high so back-to-back words flow.
    task automatic send_word(logic [1:0] op, logic [ID_BITS-1:0] id,
                             logic [DELAY_BITS-1:0] dly);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start      <= 1'b1;
        i_opcode   <= op;
        i_timer_id <= id;
        i_delay    <= dly;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(apply_timer_cmd(op, id, dly));
        n_words++;
    endtask

    // Drop start and wait until every expected result has come back.
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Write the tick amount while the block is idle.
    task automatic write_tick_amount(logic [TICK_BITS-1:0] amount);
        wait_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= amount;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        tick_amt = amount;
        n_settings++;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Tick and remove on an empty list, plus the unused opcode.
    task automatic test_empty_queue();
        send_word(OP_TICK, 8'd0, 32'd0);
        send_word(OP_REMOVE, 8'd5, 32'd0);
        send_word(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF);
    endtask

    // Zero delay, extreme ids and delays, equal expiry, refusal order.
    task automatic test_add_rules();
        send_word(OP_ADD, 8'd0, 32'd0);
        send_word(OP_ADD, 8'd0, 32'hFFFF_FFFF);
        send_word(OP_ADD, 8'd255, 32'd1);
        send_word(OP_ADD, 8'd9, 32'd3);
        send_word(OP_ADD, 8'd10, 32'd3);
        send_word(OP_ADD, 8'd255, 32'd0);
        send_word(OP_ADD, 8'd255, 32'd7);
    endtask

    // Remove an unknown id, then one in the middle so its delta moves on.
    task automatic test_remove();
        send_word(OP_REMOVE, 8'd200, 32'd0);
        send_word(OP_REMOVE, 8'd9, 32'd0);
    endtask

    // Expire the head, then lower the next one without expiring it.
    task automatic test_tick_expiry();
        send_word(OP_TICK, 8'd0, 32'd0);
        send_word(OP_TICK, 8'd0, 32'd0);
    endtask

    // Fill the store, then hit the full refusal with two more adds.
    task automatic test_full_store();
        while (q_count < MAX_TIMERS) send_word(OP_ADD, 8'(100 + q_count), 32'(q_count * 37));
        send_word(OP_ADD, 8'd120, 32'd5);
        send_word(OP_ADD, 8'd101, 32'd5);
    endtask

    // Zero tick amount leaves a nonzero head; the largest one overshoots it.
    task automatic test_tick_extremes();
        write_tick_amount(16'd0);
        send_word(OP_TICK, 8'd0, 32'd0);
        write_tick_amount(16'hFFFF);
        send_word(OP_TICK, 8'd0, 32'd0);
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------

    // Pick a delay scaled to the tick amount so timers both expire and linger.
    function automatic logic [DELAY_BITS-1:0] pick_delay();
        int r;
        r = $urandom_range(99);
        if (r < 5)  return '0;
        if (r < 11) return $urandom;
        if (r < 14) return '1;
        return $urandom_range(1, int'(tick_amt) * 8 + 8);
    endfunction

    // Generate one word from the current list: removes mostly of queued ids,
    // adds from a small id pool so duplicates and a full store come up.
    task automatic send_random_word(int add_weight);
        int r;
        logic [1:0] op;
        logic [ID_BITS-1:0] id;
        r = $urandom_range(99);
        if (r < 4)                    op = OP_UNUSED;
        else if (r < 4 + add_weight)  op = OP_ADD;
        else if (r < 22 + add_weight) op = OP_REMOVE;
        else                          op = OP_TICK;
        if (op == OP_REMOVE && q_count > 0 && $urandom_range(99) < 70)
            id = q_id[$urandom_range(0, q_count - 1)];
        else if ($urandom_range(99) < 80)
            id = 8'($urandom_range(0, 23));
        else
            id = 8'($urandom_range(0, 255));
        send_word(op, id, pick_delay());
    endtask

    // One phase: set the tick amount and idle rate, then send bursts of words, each
    // drawn at random as fill-heavy or drain-heavy, so the list swings between empty and full.
    task automatic test_random_traffic(int n, int pct, logic [TICK_BITS-1:0] amount);
        int left;
        int burst;
        write_tick_amount(amount);
        idle_pct = pct;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(8, 30);
            if (burst > left) burst = left;
            repeat (burst) send_random_word($urandom_range(0, 1) ? 50 : 25);
            left -= burst;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_queue();
        test_add_rules();
        test_remove();
        test_tick_expiry();
        test_full_store();
        test_tick_extremes();

        // Sender draws idle cycles at a 38 percent rate, then 87, then never.
        test_random_traffic(175, 38, 16'd1);
        test_random_traffic(175, 38, 16'hFFFF);
        test_random_traffic(175, 87, 16'd0);
        test_random_traffic(175, 87, 16'($urandom_range(2, 300)));
        test_random_traffic(175, 0, 16'd16);
        test_random_traffic(175, 0, 16'd1);

        // Let the last result arrive, then give the block its longest latency.
        wait_idle();
        repeat (MAX_TIMERS + 4) @(posedge i_clk);

        $display("Ran %0d command words over %0d tick amount settings:", n_words, n_settings);
        $display("  %0d timers expired, %0d adds refused, %0d errors", n_expired, n_refused,
                 n_fail);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: delta_list_timer_queue_core.f
+incdir+hw/rtl
hw/rtl/dltq_pkg.sv
hw/rtl/dltq_cell.sv
hw/rtl/delta_list_timer_queue_core.sv
hw/rtl/dltq_checker.sv
test/testbench.sv
